[sv/mps_pkg.sv]
// Shared types, codes and sizes for the masked aligned pattern search block.
package mps_pkg;

   // Pattern store depth and derived widths
   localparam int MAX_PATTERN = 64;
   localparam int PIDX_W      = $clog2(MAX_PATTERN);

   // Fixed field widths of the request and result
   localparam int CMD_W      = 2;
   localparam int INDEX_W    = 6;
   localparam int BYTE_W     = 8;
   localparam int ADDR_W     = 64;
   localparam int CSR_DATA_W = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int ALIGN_W    = 2;
   localparam int AMASK_W    = 3;

   // Request command codes
   localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DATA = 2'd1;
   localparam logic [CMD_W-1:0] CMD_JUMP = 2'd2;

   // Work kinds handed from the front to the back
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DATA = 2'd1;
   localparam logic [KIND_W-1:0] KIND_JUMP = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ALIGN_CODE     = 1'd1;

   // Alignment codes
   localparam logic [ALIGN_W-1:0] ALIGN_BYTE  = 2'd0;
   localparam logic [ALIGN_W-1:0] ALIGN_HALF  = 2'd1;
   localparam logic [ALIGN_W-1:0] ALIGN_WORD  = 2'd2;
   localparam logic [ALIGN_W-1:0] ALIGN_DWORD = 2'd3;

   // Reset values: length 4 (last position 3), word alignment
   localparam logic [PIDX_W-1:0]  RESET_LAST_POS   = PIDX_W'(3);
   localparam logic [AMASK_W-1:0] RESET_ALIGN_MASK = 3'b011;

   // Request queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [PIDX_W-1:0] index;
      logic [BYTE_W-1:0] pattern_byte;
      logic [BYTE_W-1:0] mask_byte;
      logic [BYTE_W-1:0] data_byte;
      logic [ADDR_W-1:0] new_address;
   } item_type;

   typedef struct packed {
      logic [PIDX_W-1:0]  last_pos;
      logic [AMASK_W-1:0] align_mask;
   } cfg_type;

   typedef struct packed {
      logic              empty;
      logic              full;
      logic [QCNT_W-1:0] count;
   } queue_status_type;

   typedef struct packed {
      logic pop;
      logic exec_data;
   } back_status_type;

endpackage

[sv/mps_front.sv]
// Request decoder: classifies each incoming request into a work item or drops it.
module mps_front (
   input  logic [mps_pkg::CMD_W-1:0]   req_command,
   input  logic [mps_pkg::INDEX_W-1:0] req_index,
   input  logic [mps_pkg::BYTE_W-1:0]  req_pattern_byte,
   input  logic [mps_pkg::BYTE_W-1:0]  req_mask_byte,
   input  logic [mps_pkg::BYTE_W-1:0]  req_data_byte,
   input  logic [mps_pkg::ADDR_W-1:0]  req_new_address,
   output logic                        item_keep,
   output mps_pkg::item_type           item
);
   import mps_pkg::*;

   logic index_in_range;

   // Loads beyond the store are dropped
   assign index_in_range = int'(req_index) < MAX_PATTERN;

   // Pack the payload and decode the command; the unused code is dropped
   always_comb begin
      item.index        = PIDX_W'(req_index);
      item.pattern_byte = req_pattern_byte;
      item.mask_byte    = req_mask_byte;
      item.data_byte    = req_data_byte;
      item.new_address  = req_new_address;
      unique case (req_command)
         CMD_LOAD: begin
            item.kind = KIND_LOAD;
            item_keep = index_in_range;
         end
         CMD_DATA: begin
            item.kind = KIND_DATA;
            item_keep = 1'b1;
         end
         CMD_JUMP: begin
            item.kind = KIND_JUMP;
            item_keep = 1'b1;
         end
         default: begin
            item.kind = KIND_LOAD;
            item_keep = 1'b0;
         end
      endcase
   end

endmodule

[sv/mps_queue.sv]
// Short work queue that decouples the request decoder from the search engine.
module mps_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  mps_pkg::item_type          push_item,
   input  logic                       pop,
   output mps_pkg::item_type          head_item,
   output mps_pkg::queue_status_type  status
);
   import mps_pkg::*;

   item_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming work item
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item    = slot_ff[rd_ptr_ff];
   assign status.empty = count_ff == QCNT_W'(0);
   assign status.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign status.count = count_ff;

endmodule

[sv/mps_back.sv]
// Search engine: pattern stores, shift-and match vector, address counter, result register.
module mps_back (
   input  logic                       clock,
   input  logic                       reset,
   input  mps_pkg::cfg_type           cfg,
   input  logic                       head_valid,
   input  mps_pkg::item_type          head_item,
   output mps_pkg::back_status_type   status,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [mps_pkg::ADDR_W-1:0] rsp_match_address
);
   import mps_pkg::*;

   logic [BYTE_W-1:0]      pat_ff [MAX_PATTERN];
   logic [BYTE_W-1:0]      msk_ff [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] vec_ff, vec_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]      rsp_addr_ff, rsp_addr_in;

   logic                   go;
   logic                   aligned;
   logic [MAX_PATTERN-1:0] prev_vec;
   logic [MAX_PATTERN-1:0] hit_vec;
   logic [MAX_PATTERN-1:0] next_vec;
   logic                   full_match;
   logic [ADDR_W-1:0]      match_base;

   // Execute the head item; a data item needs a free or draining result slot
   assign go = head_valid &&
               (head_item.kind != KIND_DATA || !rsp_valid_ff || !rsp_stall);

   assign aligned  = (addr_ff[AMASK_W-1:0] & cfg.align_mask) == '0;
   assign prev_vec = {vec_ff[MAX_PATTERN-2:0], aligned};

   // One masked comparator per pattern position
   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         hit_vec[i]  = ((head_item.data_byte ^ pat_ff[i]) & msk_ff[i]) == '0;
         next_vec[i] = hit_vec[i] && prev_vec[i] && (PIDX_W'(i) <= cfg.last_pos);
      end
   end

   assign full_match = next_vec[cfg.last_pos];
   assign match_base = addr_ff - ADDR_W'(cfg.last_pos);

   // Next state of the scan and the result slot
   always_comb begin
      vec_in       = vec_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_addr_in  = rsp_addr_ff;
      if (go) begin
         case (head_item.kind)
            KIND_DATA: begin
               vec_in       = next_vec;
               addr_in      = addr_ff + ADDR_W'(1);
               rsp_valid_in = full_match;
               rsp_addr_in  = match_base;
            end
            KIND_JUMP: begin
               vec_in  = '0;
               addr_in = head_item.new_address;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_ff       <= '0;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vec_ff       <= vec_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_addr_ff <= rsp_addr_in;
   end

   // Write pattern and mask bytes on a load
   always_ff @(posedge clock) begin
      if (go && head_item.kind == KIND_LOAD) begin
         pat_ff[head_item.index] <= head_item.pattern_byte;
         msk_ff[head_item.index] <= head_item.mask_byte;
      end
   end

   assign status.pop       = go;
   assign status.exec_data = go && head_item.kind == KIND_DATA;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_match_address = rsp_addr_ff;

endmodule

[sv/masked_aligned_pattern_search.sv]
// Top level of the masked aligned pattern search: configuration registers and block wiring.
//
// Scans a byte stream for a masked pattern of up to 64 bytes whose first byte sits at an
// address that is a multiple of 1, 2, 4 or 8. Load requests fill the pattern and mask
// stores, jump requests set the scan address and clear partial matches, and data requests
// present one memory byte each. Every request type is taken at one per cycle while there
// is queue room: a request enters a four-entry queue on acceptance, the search engine
// executes it from the queue head with one masked comparator per pattern position, and
// a match address is registered onto the result port in the cycle after execution.
// The input stalls only when the queue fills, which happens when the result port is held
// stalled while data requests wait behind a pending match. There is no clearing pass after
// reset; pattern_length and align_code must only be written while the block is idle.
module masked_aligned_pattern_search (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [mps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mps_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [mps_pkg::CMD_W-1:0]      req_command,
   input  logic [mps_pkg::INDEX_W-1:0]    req_index,
   input  logic [mps_pkg::BYTE_W-1:0]     req_pattern_byte,
   input  logic [mps_pkg::BYTE_W-1:0]     req_mask_byte,
   input  logic [mps_pkg::BYTE_W-1:0]     req_data_byte,
   input  logic [mps_pkg::ADDR_W-1:0]     req_new_address,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [mps_pkg::ADDR_W-1:0]     rsp_match_address
);
   import mps_pkg::*;

   logic [PIDX_W-1:0]  last_pos_ff, last_pos_in;
   logic [AMASK_W-1:0] align_mask_ff, align_mask_in;
   cfg_type            cfg;

   logic               item_keep;
   item_type           front_item;
   item_type           head_item;
   logic               push;
   queue_status_type   q_status;
   back_status_type    b_status;

   // Decode configuration writes; clamp the length and expand the alignment
   always_comb begin
      last_pos_in   = last_pos_ff;
      align_mask_in = align_mask_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_PATTERN_LENGTH: begin
               if (csr_write_data == '0) begin
                  last_pos_in = '0;
               end else if (int'(csr_write_data) > MAX_PATTERN) begin
                  last_pos_in = PIDX_W'(MAX_PATTERN - 1);
               end else begin
                  last_pos_in = PIDX_W'(csr_write_data - CSR_DATA_W'(1));
               end
            end
            REG_ALIGN_CODE: begin
               unique case (csr_write_data[ALIGN_W-1:0])
                  ALIGN_BYTE:  align_mask_in = 3'b000;
                  ALIGN_HALF:  align_mask_in = 3'b001;
                  ALIGN_WORD:  align_mask_in = 3'b011;
                  ALIGN_DWORD: align_mask_in = 3'b111;
                  default:     align_mask_in = align_mask_ff;
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_pos_ff   <= RESET_LAST_POS;
         align_mask_ff <= RESET_ALIGN_MASK;
      end else begin
         last_pos_ff   <= last_pos_in;
         align_mask_ff <= align_mask_in;
      end
   end

   assign cfg.last_pos   = last_pos_ff;
   assign cfg.align_mask = align_mask_ff;

   // Accept a request whenever the queue has room
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full && item_keep;

   mps_front u_front (
      .req_command      (req_command),
      .req_index        (req_index),
      .req_pattern_byte (req_pattern_byte),
      .req_mask_byte    (req_mask_byte),
      .req_data_byte    (req_data_byte),
      .req_new_address  (req_new_address),
      .item_keep        (item_keep),
      .item             (front_item)
   );

   mps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (b_status.pop),
      .head_item (head_item),
      .status    (q_status)
   );

   mps_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .head_valid        (!q_status.empty),
      .head_item         (head_item),
      .status            (b_status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_match_address (rsp_match_address)
   );

   // Never execute from an empty queue
   assert property (@(posedge clock) disable iff (reset)
      b_status.pop |-> !q_status.empty)
      else $error("search engine popped an empty queue");

   // Queue occupancy stays within its depth
   assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QCNT_W'(QUEUE_DEPTH))
      else $error("request queue overflow");

   // A new result only follows an executed data request
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(b_status.exec_data))
      else $error("result raised without a data request");

   // A waiting result is not replaced while the port is stalled
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !b_status.exec_data)
      else $error("data request executed over a pending result");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the masked aligned pattern search block.
module testbench;
   import mps_pkg::*;

   // Command value that the block must ignore
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   // Cycles without any accepted request or result before the run is abandoned
   localparam int WATCHDOG_LIMIT = 5000;
   // Cycles to let in-flight loads and jumps retire before a register write
   localparam int SETTLE_CYCLES = 4;
   // Length of the long result-side hold
   localparam int LONG_HOLD = 400;

   typedef struct {
      logic [CMD_W-1:0]   command;
      logic [INDEX_W-1:0] index;
      logic [BYTE_W-1:0]  pattern_byte;
      logic [BYTE_W-1:0]  mask_byte;
      logic [BYTE_W-1:0]  data_byte;
      logic [ADDR_W-1:0]  new_address;
   } request_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   logic                  req_valid;
   logic                  req_stall;
   logic [CMD_W-1:0]      req_command;
   logic [INDEX_W-1:0]    req_index;
   logic [BYTE_W-1:0]     req_pattern_byte;
   logic [BYTE_W-1:0]     req_mask_byte;
   logic [BYTE_W-1:0]     req_data_byte;
   logic [ADDR_W-1:0]     req_new_address;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [ADDR_W-1:0]     rsp_match_address;

   // Scan state mirrored from accepted requests
   logic [BYTE_W-1:0]      pat_mirror [MAX_PATTERN];
   logic [BYTE_W-1:0]      msk_mirror [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] partial_runs;
   logic [ADDR_W-1:0]      scan_addr;
   logic [CSR_DATA_W-1:0]  cfg_length;
   logic [ALIGN_W-1:0]     cfg_align;
   logic [ADDR_W-1:0]      expected_matches [$];

   int  error_count;
   int  data_count;
   int  load_count;
   int  jump_count;
   int  ignored_count;
   int  request_count;
   int  match_count;
   int  write_count;
   int  idle_cycles;
   int  stall_left;
   int  hold_left;
   bit  quiet;

   masked_aligned_pattern_search u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_index         (req_index),
      .req_pattern_byte  (req_pattern_byte),
      .req_mask_byte     (req_mask_byte),
      .req_data_byte     (req_data_byte),
      .req_new_address   (req_new_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_match_address (rsp_match_address)
   );

   // Free-running clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Advance the mirrored scan state by one accepted request
   function automatic void advance_scan(request_type r);
      logic [MAX_PATTERN-1:0] next_runs;
      logic [ADDR_W-1:0]      amask;
      int                     eff_len;
      logic                   aligned;
      logic                   hit;
      logic                   prev_bit;
      case (r.command)
         CMD_LOAD: begin
            pat_mirror[r.index] = r.pattern_byte;
            msk_mirror[r.index] = r.mask_byte;
            load_count++;
         end
         CMD_JUMP: begin
            scan_addr = r.new_address;
            partial_runs = '0;
            jump_count++;
         end
         CMD_DATA: begin
            eff_len = (cfg_length == 0) ? 1 : ((cfg_length > MAX_PATTERN) ? MAX_PATTERN
                                                                          : int'(cfg_length));
            amask = (64'd1 << cfg_align) - 64'd1;
            aligned = (scan_addr & amask) == 64'd0;
            next_runs = '0;
            for (int i = 0; i < eff_len; i++) begin
               hit = ((r.data_byte ^ pat_mirror[i]) & msk_mirror[i]) == 8'd0;
               prev_bit = (i == 0) ? aligned : partial_runs[i-1];
               next_runs[i] = hit && prev_bit;
            end
            partial_runs = next_runs;
            if (partial_runs[eff_len-1])
               expected_matches.push_back(scan_addr - 64'(eff_len - 1));
            scan_addr = scan_addr + 64'd1;
            data_count++;
         end
         default: begin
            ignored_count++;
         end
      endcase
      if (r.command != CMD_UNUSED)
         request_count++;
   endfunction

   // Random request with every field filled, so unused fields toggle too
   function automatic request_type random_request();
      request_type r;
      r.command      = CMD_W'($urandom);
      r.index        = INDEX_W'($urandom);
      r.pattern_byte = BYTE_W'($urandom);
      r.mask_byte    = BYTE_W'($urandom);
      r.data_byte    = BYTE_W'($urandom);
      r.new_address  = {$urandom, $urandom};
      return r;
   endfunction

   // Offer one request after a random gap and hold it until accepted
   task automatic send_request(request_type r);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 15);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_command      <= r.command;
      req_index        <= r.index;
      req_pattern_byte <= r.pattern_byte;
      req_mask_byte    <= r.mask_byte;
      req_data_byte    <= r.data_byte;
      req_new_address  <= r.new_address;
      do @(posedge clock); while (req_stall);
      advance_scan(r);
   endtask

   task automatic send_load(int idx, logic [7:0] pat, logic [7:0] msk);
      request_type r;
      r = random_request();
      r.command = CMD_LOAD;
      r.index = INDEX_W'(idx);
      r.pattern_byte = pat;
      r.mask_byte = msk;
      send_request(r);
   endtask

   task automatic send_data(logic [7:0] value);
      request_type r;
      r = random_request();
      r.command = CMD_DATA;
      r.data_byte = value;
      send_request(r);
   endtask

   task automatic send_jump(logic [63:0] addr);
      request_type r;
      r = random_request();
      r.command = CMD_JUMP;
      r.new_address = addr;
      send_request(r);
   endtask

   task automatic send_unused();
      request_type r;
      r = random_request();
      r.command = CMD_UNUSED;
      send_request(r);
   endtask

   // Send bytes that satisfy the stored pattern, don't-care bits random
   task automatic send_pattern_copy(int first, int count, bit corrupt);
      int         bad;
      logic [7:0] value;
      bad = corrupt ? $urandom_range(first, first + count - 1) : -1;
      for (int i = first; i < first + count; i++) begin
         value = (pat_mirror[i] & msk_mirror[i]) | (8'($urandom) & ~msk_mirror[i]);
         if (i == bad)
            value = value ^ 8'($urandom_range(1, 255));
         send_data(value);
      end
   endtask

   // Drop valid and wait until every expected match has returned
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_matches.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == REG_PATTERN_LENGTH)
         cfg_length = value;
      else
         cfg_align = value[ALIGN_W-1:0];
      write_count++;
   endtask

   task automatic set_config(logic [CSR_DATA_W-1:0] len, logic [ALIGN_W-1:0] align);
      wait_idle();
      write_register(REG_PATTERN_LENGTH, len);
      write_register(REG_ALIGN_CODE, CSR_DATA_W'(align));
   endtask

   function automatic logic [63:0] random_address();
      return {$urandom, $urandom};
   endfunction

   // Fill both stores so that no data request reads an unwritten entry
   task automatic test_load_stores();
      send_load(0, 8'h00, 8'hFF);
      send_load(MAX_PATTERN - 1, 8'hFF, 8'h00);
      for (int i = 1; i < MAX_PATTERN - 1; i++)
         send_load(i, 8'($urandom), 8'($urandom));
   endtask

   // Basic match at reset settings, masks, ignored command, load mid-scan, misalignment, wrap
   task automatic test_directed_match();
      send_load(0, 8'hDE, 8'hFF);
      send_load(1, 8'hAD, 8'hFF);
      send_load(2, 8'hBE, 8'h0F);
      send_load(3, 8'hEF, 8'hFF);
      send_jump(64'h1000);
      send_data(8'hDE);
      send_data(8'hAD);
      send_unused();
      send_load(40, 8'h55, 8'hFF);
      send_data(8'h5E);
      send_data(8'hEF);
      // misaligned start gives no match
      send_jump(64'h1002);
      send_data(8'hDE);
      send_data(8'hAD);
      send_data(8'hBE);
      send_data(8'hEF);
      // scan address wraps to zero before the match starts
      send_jump(64'hFFFF_FFFF_FFFF_FFFF);
      send_data(8'hFF);
      send_data(8'hDE);
      send_data(8'hAD);
      send_data(8'hBE);
      send_data(8'hEF);
      send_data(8'h00);
   endtask

   // Partial matches carrying across the top of the address space
   task automatic test_address_wrap();
      set_config(7'd2, ALIGN_BYTE);
      send_jump(64'hFFFF_FFFF_FFFF_FFFF);
      send_data(8'hDE);
      send_data(8'hAD);
      set_config(7'd4, ALIGN_DWORD);
      send_jump(64'hFFFF_FFFF_FFFF_FFFE);
      send_pattern_copy(0, 4, 1'b0);
      send_jump(64'hFFFF_FFFF_FFFF_FFF8);
      send_pattern_copy(0, 4, 1'b0);
      set_config(7'd4, ALIGN_HALF);
      send_jump(64'hFFFF_FFFF_FFFF_FFFE);
      send_pattern_copy(0, 4, 1'b0);
   endtask

   // Length register extremes and a length change in the middle of a run
   task automatic test_length_limits();
      set_config(7'd0, ALIGN_BYTE);
      send_data(8'hDE);
      send_data(8'hDF);
      send_data(8'hDE);
      set_config(7'd127, ALIGN_WORD);
      send_jump(64'd0);
      send_pattern_copy(0, MAX_PATTERN, 1'b0);
      set_config(7'd64, ALIGN_DWORD);
      send_jump(64'h40);
      send_pattern_copy(0, MAX_PATTERN, 1'b0);
      set_config(7'd8, ALIGN_BYTE);
      send_jump(64'h200);
      send_pattern_copy(0, 4, 1'b0);
      set_config(7'd3, ALIGN_BYTE);
      send_pattern_copy(0, 6, 1'b0);
      set_config(7'd100, ALIGN_HALF);
      send_jump(64'h8000_0000_0000_0000);
      send_pattern_copy(0, MAX_PATTERN, 1'b1);
   endtask

   // Hold the result side long enough to fill the block, then drain and resume
   task automatic test_backpressure();
      set_config(7'd1, ALIGN_BYTE);
      send_load(0, 8'($urandom), 8'h00);
      @(posedge clock);
      hold_left = LONG_HOLD;
      quiet = 1'b1;
      repeat (40) send_data(8'($urandom));
      quiet = 1'b0;
      // pause the sender until every match has come back
      wait_idle();
      repeat (20) send_data(8'($urandom));
   endtask

   // Random phases, each with its own settings, mostly well-formed pattern runs
   task automatic test_random_scan(int phases, int per_phase);
      int              len_value;
      int              eff;
      int              sel;
      int              start;
      int              lead;
      logic [1:0]      align;
      logic [63:0]     amask;
      logic [63:0]     addr;
      logic [7:0]      mval;
      for (int p = 0; p < phases; p++) begin
         sel = $urandom_range(0, 9);
         if (sel < 6)
            len_value = $urandom_range(1, 8);
         else if (sel == 6)
            len_value = $urandom_range(9, 63);
         else if (sel == 7)
            len_value = MAX_PATTERN;
         else if (sel == 8)
            len_value = 0;
         else
            len_value = $urandom_range(65, 127);
         eff = (len_value == 0) ? 1 : ((len_value > MAX_PATTERN) ? MAX_PATTERN : len_value);
         align = 2'($urandom_range(0, 3));
         set_config(7'(len_value), align);
         amask = (64'd1 << align) - 64'd1;
         quiet = ($urandom_range(0, 3) == 0);
         // fresh pattern, mostly exact bytes with some partial and empty masks
         for (int i = 0; i < eff; i++) begin
            sel = $urandom_range(0, 9);
            mval = (sel < 7) ? 8'hFF : ((sel < 9) ? 8'($urandom) : 8'h00);
            send_load(i, 8'($urandom), mval);
         end
         start = request_count;
         while (request_count - start < per_phase) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
               addr = random_address();
               if ($urandom_range(0, 7) == 0)
                  addr = {56'hFF_FFFF_FFFF_FFFF, 8'($urandom)};
               send_jump(addr & ~amask);
               lead = $urandom_range(0, 2) << align;
               repeat (lead) send_data(8'($urandom));
               send_pattern_copy(0, eff, $urandom_range(0, 4) == 0);
               if ($urandom_range(0, 3) == 0)
                  send_pattern_copy(0, eff, 1'b0);
            end else if (sel < 80) begin
               repeat ($urandom_range(1, 8)) send_data(8'($urandom));
            end else if (sel < 88) begin
               send_jump(random_address());
            end else if (sel < 95) begin
               send_load($urandom_range(0, MAX_PATTERN - 1), 8'($urandom), 8'($urandom));
            end else begin
               send_unused();
            end
         end
         quiet = 1'b0;
      end
   endtask

   // Compare each accepted match with the oldest expectation
   always @(posedge clock) begin
      logic [ADDR_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_matches.size() == 0) begin
            $error("match_address: got %h with no match expected", rsp_match_address);
            error_count++;
         end else begin
            want = expected_matches.pop_front();
            if (rsp_match_address !== want) begin
               $error("match_address: expected %h, actual %h", want, rsp_match_address);
               error_count++;
            end
         end
         match_count++;
         stall_left = quiet ? 0 : $urandom_range(0, 15);
      end
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
   end

   // Drive the result-side stall: long hold first, then per-result random stalls
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Abandon the run when nothing moves for too long
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      $display("testbench: errors");
      $finish;
   end

   // Test sequence
   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_command      = '0;
      req_index        = '0;
      req_pattern_byte = '0;
      req_mask_byte    = '0;
      req_data_byte    = '0;
      req_new_address  = '0;
      error_count   = 0;
      data_count    = 0;
      load_count    = 0;
      jump_count    = 0;
      ignored_count = 0;
      request_count = 0;
      match_count   = 0;
      write_count   = 0;
      stall_left    = 0;
      hold_left     = 0;
      quiet         = 1'b0;
      partial_runs  = '0;
      scan_addr     = '0;
      cfg_length    = 7'd4;
      cfg_align     = ALIGN_WORD;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_load_stores();
      test_directed_match();
      test_address_wrap();
      test_length_limits();
      test_backpressure();
      test_random_scan(8, 140);

      // drain outstanding matches and let the pipeline settle
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_matches.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (expected_matches.size() != 0) begin
         $error("match_address: %0d expected matches never arrived", expected_matches.size());
         error_count++;
      end

      $display("covered %0d data, %0d load, %0d jump and %0d ignored requests",
               data_count, load_count, jump_count, ignored_count);
      $display("checked %0d match addresses over %0d register writes",
               match_count, write_count);
      if (error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
